// ----- rtl/rsaeps_pkg.sv -----
package rsaeps_pkg;

	localparam int unsigned EW = 32;
	localparam int unsigned PW = 16;
	localparam int unsigned CW = 7;

	localparam logic [PW-1:0] P_RESET = 16'd59;
	localparam logic [PW-1:0] Q_RESET = 16'd83;
	localparam logic [EW-1:0] T_RESET = 32'd4756;

	localparam logic REG_P = 1'b0;
	localparam logic REG_Q = 1'b1;

	typedef struct packed {
		logic          start;
		logic [EW-1:0] dividend;
		logic [EW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [EW-1:0] quo;
		logic [EW-1:0] rem;
	} div_rsp_t;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CHECK = 11'b000_0000_0010,
		S_TOTW  = 11'b000_0000_0100,
		S_TRIAL = 11'b000_0000_1000,
		S_TRIW  = 11'b000_0001_0000,
		S_EUC   = 11'b000_0010_0000,
		S_EUCW  = 11'b000_0100_0000,
		S_MUL   = 11'b000_1000_0000,
		S_SUB   = 11'b001_0000_0000,
		S_FIX   = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

endpackage

// ----- rtl/rsaeps_div.sv -----
module rsaeps_div
	import rsaeps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [EW-1:0] rem_q;
	logic [EW-1:0] quo_q;
	logic [EW-1:0] dvs_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [EW:0]   shifted;
	logic [EW:0]   diff;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[EW-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[EW]) begin
				rem_q <= diff[EW-1:0];
				quo_q <= {quo_q[EW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[EW-1:0];
				quo_q <= {quo_q[EW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- rtl/rsa_exponent_pair_search.sv -----
// Run time is data dependent; every division runs on the one shared divider.
// One remainder test on the totient, then one division per trial factor up
// to sqrt(e), then one division plus a multiply and a subtract step per extended Euclid step.
// Throughput: one candidate at a time; in_ready is high only between candidates.
// Reset (arst_n low, asynchronous): primes 59 and 83, totient 4756, pair count 0,
// no result pending.
module rsa_exponent_pair_search
	import rsaeps_pkg::*;
#(
	parameter int unsigned MAX_PAIRS = 99
)(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic          wr_index,
	input  logic [PW-1:0] wr_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [EW-1:0] candidate,
	input  logic          restart,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          accepted,
	output logic [CW-1:0] pair_index,
	output logic [EW-1:0] exponent_e,
	output logic [EW-1:0] inverse_d,
	output logic          limit_reached
);

	localparam logic [CW-1:0] MAXC = CW'(MAX_PAIRS);

	state_t               state_q;
	logic [PW-1:0]        p_q, q_q;
	logic [EW-1:0]        tot_q;
	logic [CW-1:0]        cnt_q;
	logic [EW-1:0]        e_q;
	logic [16:0]          f_q;
	logic [33:0]          sq_q;
	logic [EW-1:0]        r0_q, r1_q, quo_q, rem_q;
	logic signed [33:0]   s0_q, s1_q, prod_q;
	logic                 ok_q;
	logic [EW-1:0]        d_q;
	logic                 pre_ok;
	logic                 sq_over;
	logic signed [33:0]   s_fix;
	div_req_t             dreq;
	div_rsp_t             drsp;
	logic [PW-1:0]        pm1, qm1;

	rsaeps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// totient on register write
	assign pm1 = ((wr_index == REG_P) ? wr_data : p_q) - 16'd1;
	assign qm1 = ((wr_index == REG_Q) ? wr_data : q_q) - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= P_RESET;
			q_q   <= Q_RESET;
			tot_q <= T_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_P) p_q <= wr_data;
			else q_q <= wr_data;
			tot_q <= {16'd0, pm1} * {16'd0, qm1};
		end
	end

	assign pre_ok = (cnt_q < MAXC) && (e_q < tot_q) && (e_q >= 32'd2)
		&& (e_q != {16'd0, p_q}) && (e_q != {16'd0, q_q});
	assign sq_over = sq_q > {2'b00, e_q};
	assign s_fix   = s0_q + $signed({2'b00, tot_q});

	// divider requests
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = e_q;
		dreq.divisor  = {15'd0, f_q};
		unique case (state_q)
			S_CHECK: begin
				dreq.start    = pre_ok;
				dreq.dividend = tot_q;
				dreq.divisor  = e_q;
			end
			S_TRIAL: dreq.start = !sq_over;
			S_EUC: begin
				dreq.start    = (r1_q != '0);
				dreq.dividend = r0_q;
				dreq.divisor  = r1_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// load a new result, or drop the one just transferred
			if (state_q == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					if (restart) cnt_q <= '0;
					state_q <= S_CHECK;
				end
				S_CHECK: state_q <= pre_ok ? S_TOTW : S_DONE;
				S_TOTW: if (drsp.done) state_q <= (drsp.rem == '0) ? S_DONE : S_TRIAL;
				S_TRIAL: state_q <= sq_over ? S_EUC : S_TRIW;
				S_TRIW: if (drsp.done) state_q <= (drsp.rem == '0) ? S_DONE : S_TRIAL;
				S_EUC: state_q <= (r1_q == '0) ? S_FIX : S_EUCW;
				S_EUCW: if (drsp.done) state_q <= S_MUL;
				S_MUL: state_q <= S_SUB;
				S_SUB: state_q <= S_EUC;
				S_FIX: state_q <= S_DONE;
				S_DONE: if (!out_valid || out_ready) begin
					if (ok_q) cnt_q <= cnt_q + 7'd1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				e_q  <= candidate;
				ok_q <= 1'b0;
			end
			S_TOTW: if (drsp.done) begin
				f_q  <= 17'd2;
				sq_q <= 34'd4;
			end
			S_TRIAL: if (sq_over) begin
				r0_q <= tot_q;
				r1_q <= e_q;
				s0_q <= '0;
				s1_q <= 34'sd1;
			end
			S_TRIW: if (drsp.done) begin
				sq_q <= sq_q + {16'd0, f_q, 1'b1};
				f_q  <= f_q + 17'd1;
			end
			S_EUCW: if (drsp.done) begin
				quo_q <= drsp.quo;
				rem_q <= drsp.rem;
			end
			S_MUL: prod_q <= 34'($signed({2'b00, quo_q}) * s1_q);
			S_SUB: begin
				s0_q <= s1_q;
				s1_q <= s0_q - prod_q;
				r0_q <= r1_q;
				r1_q <= rem_q;
			end
			S_FIX: begin
				d_q  <= s0_q[33] ? s_fix[EW-1:0] : s0_q[EW-1:0];
				ok_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			accepted      <= ok_q;
			pair_index    <= ok_q ? cnt_q : '0;
			exponent_e    <= e_q;
			inverse_d     <= ok_q ? d_q : '0;
			limit_reached <= ((ok_q ? cnt_q + 7'd1 : cnt_q) >= MAXC);
		end
	end

endmodule

// ----- rtl/rsaeps_checker.sv -----
module rsaeps_checker
	import rsaeps_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input logic          accepted,
	input logic [CW-1:0] pair_index,
	input logic [EW-1:0] exponent_e,
	input logic [EW-1:0] inverse_d
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inverse_d) && $stable(exponent_e))
		else $error("result changed while stalled");

	// rejected candidates carry zero index and inverse
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> pair_index == '0 && inverse_d == '0)
		else $error("rejected result with nonzero fields");

	// accepted pair has a real inverse
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> inverse_d != '0 && exponent_e >= 32'd2)
		else $error("accepted pair with bad fields");

endmodule

bind rsa_exponent_pair_search rsaeps_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.accepted   (accepted),
	.pair_index (pair_index),
	.exponent_e (exponent_e),
	.inverse_d  (inverse_d)
);
